// ===== rtl/csmm_pkg.sv =====
// ----------------------------------------------------------------------------
// csmm_pkg
// shared types and constants of the complex square matrix multiplier
// ----------------------------------------------------------------------------
package csmm_pkg;

    localparam int ELEM_W  = 18;
    localparam int WORD_W  = 2 * ELEM_W;
    localparam int PROD_W  = 40;
    localparam int PADDR_W = 3;

    localparam logic [PADDR_W-1:0] ADDR_MATRIX_SIZE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_SQUARE_MODE = 3'd4;

    typedef struct packed {
        logic                     clear;
        logic                     en;
    } t_cell_ctrl;

endpackage

// ===== rtl/csmm_if.sv =====
// ----------------------------------------------------------------------------
// csmm_elem_if / csmm_prod_if
// valid/ready channels of the matrix multiplier
// ----------------------------------------------------------------------------
interface csmm_elem_if;
    logic              valid;
    logic              ready;
    logic signed [17:0] elem_re;
    logic signed [17:0] elem_im;
    modport source (output valid, elem_re, elem_im, input ready);
    modport sink   (input valid, elem_re, elem_im, output ready);
endinterface

interface csmm_prod_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] prod_re;
    logic signed [39:0] prod_im;
    logic               last_elem;
    modport source (output valid, prod_re, prod_im, last_elem, input ready);
    modport sink   (input valid, prod_re, prod_im, last_elem, output ready);
endinterface

// ===== rtl/complex_square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// complex_square_matrix_multiply
// n by n complex matrix product on a row of MAC cells
// ----------------------------------------------------------------------------
// Elements of A (then B unless square_mode) are taken one per cycle. After
// the last load the block computes one product row at a time: for k = 0..n-1
// element A[row][k] passes along a row of MAX_DIM complex MAC cells, cell c
// reading B[k][c] from its own RAM lane; after the pipeline drains, the n
// results of the row are delivered one per accepted output transaction. No
// item is accepted while the products are computed or delivered. No clearing
// pass is needed.
module complex_square_matrix_multiply import csmm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    csmm_elem_if.sink           s_elem,
    csmm_prod_if.source         m_prod,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW    = $clog2(2 * DEPTH + 1);
    localparam int LAT   = 4;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [3:0]    r_size;
    logic          r_sq;
    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_row, r_k, r_col;
    logic [3:0]    r_wait;
    logic [DW-1:0] r_lrow, r_lcol;

    logic [3:0]    n_eff;
    logic [CW-1:0] n_nn, n_total;
    logic          w_cfg, w_in_acc, w_out_acc, w_is_a;

    always_comb begin
        if (r_size == 4'd0) n_eff = 4'd1;
        else if (r_size > 4'(MAX_DIM)) n_eff = 4'(MAX_DIM);
        else n_eff = r_size;
    end
    assign n_nn    = CW'(n_eff) * CW'(n_eff);
    assign n_total = r_sq ? n_nn : CW'(n_nn << 1);

    assign pready    = 1'b1;
    assign w_cfg     = psel && penable && pwrite;
    assign prdata    = (paddr == ADDR_MATRIX_SIZE) ? {28'd0, r_size} :
                       (paddr == ADDR_SQUARE_MODE) ? {31'd0, r_sq} : 32'd0;
    assign s_elem.ready = (r_state == ST_LOAD);
    assign w_in_acc  = s_elem.valid && s_elem.ready;
    assign w_out_acc = m_prod.valid && m_prod.ready;
    assign w_is_a    = r_cnt < n_nn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'd8;
            r_sq   <= 1'b0;
        end else if (w_cfg) begin
            if (paddr == ADDR_MATRIX_SIZE) r_size <= pwdata[3:0];
            if (paddr == ADDR_SQUARE_MODE) r_sq   <= pwdata[0];
        end
    end

    // matrix B is split into one RAM per column lane
    logic [WORD_W-1:0] w_word;
    logic [DW-1:0]     w_lrow, w_lcol;
    assign w_word = {s_elem.elem_re, s_elem.elem_im};
    assign w_lrow = r_lrow;
    assign w_lcol = r_lcol;

    logic [WORD_W-1:0] w_a_rd;
    csmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk  (i_clk),
        .i_we   (w_in_acc && w_is_a),
        .i_waddr(AW'(r_cnt)),
        .i_wdata(w_word),
        .i_raddr(AW'(CW'(r_row) * CW'(n_eff) + CW'(r_k))),
        .o_rdata(w_a_rd)
    );

    // extra stage lines A up with the control delay
    logic [WORD_W-1:0] r_a_q;
    always_ff @(posedge i_clk) begin
        r_a_q <= w_a_rd;
    end

    logic [WORD_W-1:0] w_b_rd [MAX_DIM];
    logic              w_b_we;
    assign w_b_we = w_in_acc && (r_sq ? 1'b1 : !w_is_a);

    t_cell_ctrl                w_ctrl [MAX_DIM+1];
    logic signed [ELEM_W-1:0]  w_are  [MAX_DIM+1];
    logic signed [ELEM_W-1:0]  w_aim  [MAX_DIM+1];
    logic signed [PROD_W-1:0]  w_sre  [MAX_DIM];
    logic signed [PROD_W-1:0]  w_sim  [MAX_DIM];
    t_cell_ctrl                r_ctl0, r_ctl1;

    assign w_are[0]  = r_a_q[WORD_W-1:ELEM_W];
    assign w_aim[0]  = r_a_q[ELEM_W-1:0];
    assign w_ctrl[0] = r_ctl1;

    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++) begin : g_lane
            logic [WORD_W-1:0] w_bd, r_bd;
            csmm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIM)) u_b_ram (
                .i_clk  (i_clk),
                .i_we   (w_b_we && (w_lcol == DW'(g))),
                .i_waddr(w_lrow),
                .i_wdata(w_word),
                .i_raddr(DW'(r_k)),
                .o_rdata(w_bd)
            );
            // delay so B meets A as it travels to cell g
            logic [WORD_W-1:0] r_dl [g+1];
            always_ff @(posedge i_clk) begin
                r_dl[0] <= w_bd;
                for (int j = 1; j <= g; j++) r_dl[j] <= r_dl[j-1];
            end
            assign w_b_rd[g] = r_dl[g];
            csmm_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_a_re  (w_are[g]),
                .i_a_im  (w_aim[g]),
                .i_b_re  (w_b_rd[g][WORD_W-1:ELEM_W]),
                .i_b_im  (w_b_rd[g][ELEM_W-1:0]),
                .o_a_re  (w_are[g+1]),
                .o_a_im  (w_aim[g+1]),
                .o_ctrl  (w_ctrl[g+1]),
                .o_acc_re(w_sre[g]),
                .o_acc_im(w_sim[g])
            );
        end
    endgenerate

    t_cell_ctrl n_ctl;
    assign n_ctl.en    = (r_state == ST_CALC);
    assign n_ctl.clear = (r_state == ST_CALC) && (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
            r_ctl1 <= '0;
        end else begin
            r_ctl0 <= n_ctl;
            r_ctl1 <= r_ctl0;
        end
    end

    // load, compute and output sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_row   <= '0;
            r_k     <= '0;
            r_col   <= '0;
            r_wait  <= '0;
            r_lrow  <= '0;
            r_lcol  <= '0;
        end else if (w_cfg) begin
            r_cnt  <= '0;
            r_lrow <= '0;
            r_lcol <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_cnt + 1'b1 >= n_total) begin
                            r_cnt   <= '0;
                            r_lrow  <= '0;
                            r_lcol  <= '0;
                            r_row   <= '0;
                            r_k     <= '0;
                            r_state <= ST_CALC;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            if ({1'b0, r_lcol} + 1'b1 == (DW+1)'(n_eff)) begin
                                r_lcol <= '0;
                                if (r_cnt + 1'b1 == n_nn) r_lrow <= '0;
                                else r_lrow <= r_lrow + 1'b1;
                            end else begin
                                r_lcol <= r_lcol + 1'b1;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    if (r_k + 1'b1 == (DW+1)'(n_eff)) begin
                        r_k     <= '0;
                        r_wait  <= 4'(LAT + MAX_DIM);
                        r_state <= ST_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (r_wait == 4'd0) begin
                        r_col   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (w_out_acc) begin
                        if (r_col + 1'b1 == (DW+1)'(n_eff)) begin
                            if (r_row + 1'b1 == (DW+1)'(n_eff)) begin
                                r_state <= ST_LOAD;
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_state <= ST_CALC;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign m_prod.valid     = (r_state == ST_OUT);
    assign m_prod.prod_re   = w_sre[DW'(r_col)];
    assign m_prod.prod_im   = w_sim[DW'(r_col)];
    assign m_prod.last_elem = (r_col + 1'b1 == (DW+1)'(n_eff)) &&
                              (r_row + 1'b1 == (DW+1)'(n_eff));

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_prod.valid |-> !s_elem.ready)
        else $error("input accepted during output");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_prod.valid && !m_prod.ready) |=> m_prod.valid && $stable(r_col))
        else $error("output dropped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_cnt <= CW'(2 * DEPTH)))
        else $error("load count overflow");
endmodule

// ===== rtl/csmm_ram.sv =====
// ----------------------------------------------------------------------------
// csmm_ram
// generic single-port-write, single-read RAM with registered read
// ----------------------------------------------------------------------------
module csmm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/csmm_cell.sv =====
// ----------------------------------------------------------------------------
// csmm_cell
// complex multiply-accumulate cell of the systolic row
// ----------------------------------------------------------------------------
module csmm_cell import csmm_pkg::*; (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic signed [ELEM_W-1:0]  i_a_re,
    input  logic signed [ELEM_W-1:0]  i_a_im,
    input  logic signed [ELEM_W-1:0]  i_b_re,
    input  logic signed [ELEM_W-1:0]  i_b_im,
    output logic signed [ELEM_W-1:0]  o_a_re,
    output logic signed [ELEM_W-1:0]  o_a_im,
    output t_cell_ctrl                o_ctrl,
    output logic signed [PROD_W-1:0]  o_acc_re,
    output logic signed [PROD_W-1:0]  o_acc_im
);
    logic signed [2*ELEM_W-1:0] r_rr, r_ii, r_ri, r_ir;
    t_cell_ctrl                 r_ctrl_m;
    logic signed [ELEM_W-1:0]   r_a_re, r_a_im;
    t_cell_ctrl                 r_ctrl;
    logic signed [PROD_W-1:0]   r_acc_re, r_acc_im;
    logic signed [PROD_W-1:0]   n_base_re, n_base_im;

    always_ff @(posedge i_clk) begin
        r_rr     <= i_a_re * i_b_re;
        r_ii     <= i_a_im * i_b_im;
        r_ri     <= i_a_re * i_b_im;
        r_ir     <= i_a_im * i_b_re;
        r_ctrl_m <= i_ctrl;
        r_a_re   <= i_a_re;
        r_a_im   <= i_a_im;
        r_ctrl   <= i_ctrl;
    end

    assign n_base_re = r_ctrl_m.clear ? '0 : r_acc_re;
    assign n_base_im = r_ctrl_m.clear ? '0 : r_acc_im;

    always_ff @(posedge i_clk) begin
        if (r_ctrl_m.en) begin
            r_acc_re <= n_base_re + PROD_W'(r_rr) - PROD_W'(r_ii);
            r_acc_im <= n_base_im + PROD_W'(r_ri) + PROD_W'(r_ir);
        end
    end

    assign o_a_re   = r_a_re;
    assign o_a_im   = r_a_im;
    assign o_ctrl   = r_ctrl;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
endmodule

// ===== sim/tb_complex_square_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the complex square matrix multiplier
// ----------------------------------------------------------------------------
// Elements are loaded over the element channel and every product element is
// compared with an in-bench matrix product. Directed loads come first,
// followed by random rounds over several sizes, square mode settings and
// handshake idling phases, including a long hold-off on the product channel.
module tb;
    import csmm_pkg::*;

    typedef struct packed {
        logic signed [ELEM_W-1:0] re;
        logic signed [ELEM_W-1:0] im;
    } t_elem;

    typedef struct packed {
        logic signed [PROD_W-1:0] re;
        logic signed [PROD_W-1:0] im;
        logic                     last;
    } t_prod;

    localparam int MAX_N        = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [ELEM_W-1:0] EMAX = 18'sh1ffff;
    localparam logic signed [ELEM_W-1:0] EMIN = -18'sh20000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    csmm_elem_if elem_ch ();
    csmm_prod_if prod_ch ();

    complex_square_matrix_multiply dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_elem  (elem_ch.sink),
        .m_prod  (prod_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    t_elem mat_a [MAX_N*MAX_N];
    t_elem mat_b [MAX_N*MAX_N];
    int    load_cnt;
    int    cfg_size;
    int    cfg_square;
    t_prod expected_prods [$];

    int    errors;
    int    cycles = 0;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_off;
    int    hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int eff_size();
        if (cfg_size < 1) return 1;
        if (cfg_size > MAX_N) return MAX_N;
        return cfg_size;
    endfunction

    function automatic void predict_load(t_elem e);
        int n, nn, total;
        t_prod p;
        logic signed [63:0] sre, sim;
        t_elem a, b;
        n = eff_size();
        nn = n * n;
        total = cfg_square ? nn : 2 * nn;
        if (load_cnt >= total) load_cnt = 0;
        if (load_cnt < nn) mat_a[load_cnt] = e;
        else mat_b[load_cnt - nn] = e;
        load_cnt++;
        if (load_cnt < total) return;
        load_cnt = 0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                sre = 0;
                sim = 0;
                for (int k = 0; k < n; k++) begin
                    a = mat_a[r*n+k];
                    b = cfg_square ? mat_a[k*n+c] : mat_b[k*n+c];
                    sre += 64'(a.re) * 64'(b.re) - 64'(a.im) * 64'(b.im);
                    sim += 64'(a.re) * 64'(b.im) + 64'(a.im) * 64'(b.re);
                end
                p.re = sre[PROD_W-1:0];
                p.im = sim[PROD_W-1:0];
                p.last = (r*n + c + 1 == nn);
                expected_prods.push_back(p);
            end
        end
    endfunction

    // product channel checker
    always @(posedge i_clk) begin
        t_prod got, want;
        if (i_rst_n && prod_ch.valid && prod_ch.ready) begin
            got.re = prod_ch.prod_re;
            got.im = prod_ch.prod_im;
            got.last = prod_ch.last_elem;
            if (expected_prods.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected product transaction re=%0d im=%0d",
                             got.re, got.im);
            end else begin
                want = expected_prods.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"product mismatch: exp re=%0d im=%0d last=%0b,",
                                  " got re=%0d im=%0d last=%0b"},
                                 want.re, want.im, want.last,
                                 got.re, got.im, got.last);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            prod_ch.ready <= 1'b0;
        end else if (hold_off) begin
            prod_ch.ready <= 1'b0;
        end else begin
            prod_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long hold-off, counted in its own process
    initial begin
        hold_off = 1'b0;
        wait (hold_cycles > 0);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (hold_cycles) @(negedge i_clk);
        hold_off = 1'b0;
    end

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_prods.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(int size, int square);
        wait_idle();
        apb_write(ADDR_MATRIX_SIZE, 32'(size));
        apb_write(ADDR_SQUARE_MODE, 32'(square));
        cfg_size = size & 15;
        cfg_square = square & 1;
        load_cnt = 0;
    endtask

    task automatic send_elem(t_elem e);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        elem_ch.valid <= 1'b1;
        elem_ch.elem_re <= e.re;
        elem_ch.elem_im <= e.im;
        do @(posedge i_clk); while (!elem_ch.ready);
        predict_load(e);
    endtask

    task automatic release_elem();
        @(negedge i_clk);
        elem_ch.valid <= 1'b0;
    endtask

    function automatic t_elem rand_elem(int mode);
        t_elem e;
        case (mode)
            0: begin e.re = EMAX; e.im = EMAX; end
            1: begin e.re = EMIN; e.im = EMIN; end
            default: begin
                e.re = ELEM_W'($urandom);
                e.im = ELEM_W'($urandom);
            end
        endcase
        return e;
    endfunction

    typedef struct {
        t_elem e;
    } t_row;

    t_row directed_rows [20];

    initial begin
        int n, rounds, mode;
        t_prod chk;
        errors = 0;
        load_cnt = 0;
        cfg_size = MAX_N;
        cfg_square = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        elem_ch.valid = 1'b0;
        elem_ch.elem_re = '0;
        elem_ch.elem_im = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 1x1 extremes (size 1 and 0), then square 2x2 with mixed extremes, then clamped 8x8
        directed_rows[0].e = '{EMIN, EMIN};
        directed_rows[1].e = '{EMIN, EMIN};
        directed_rows[2].e = '{EMAX, EMIN};
        directed_rows[3].e = '{EMAX, EMAX};
        directed_rows[4].e = '{EMAX, 18'sd0};
        directed_rows[5].e = '{18'sd0, EMIN};
        directed_rows[6].e = '{18'sd16384, 18'sd0};
        directed_rows[7].e = '{18'sd0, 18'sd16384};
        directed_rows[8].e = '{-18'sd1, 18'sd1};
        directed_rows[9].e = '{EMIN, EMAX};
        set_config(1, 0);
        for (int i = 0; i < 2; i++) send_elem(directed_rows[i].e);
        release_elem();
        // (-2^17 + -2^17 j)^2 = 0 + 2^35 j
        chk = '{40'sd0, 40'sd34359738368, 1'b1};
        if (expected_prods.size() != 1 || expected_prods[0] !== chk) begin
            errors++;
            $display("directed extreme prediction off");
        end
        set_config(1, 1);
        send_elem(directed_rows[2].e);
        release_elem();
        set_config(0, 0);
        for (int i = 3; i < 5; i++) send_elem(directed_rows[i].e);
        release_elem();
        set_config(2, 1);
        for (int i = 5; i < 9; i++) send_elem(directed_rows[i].e);
        release_elem();
        set_config(15, 1);
        for (int i = 0; i < 64; i++) send_elem(rand_elem(i % 3));
        release_elem();

        // random rounds over idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 85 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 85 : 0;
            rounds = 0;
            while (rounds < 6) begin
                n = ($urandom_range(9) == 0) ? MAX_N : $urandom_range(1, 4);
                set_config(n, $urandom_range(1));
                if (ph == 0 && rounds == 2) hold_cycles = 3000;
                mode = $urandom_range(9);
                for (int i = 0; i < (cfg_square ? n*n : 2*n*n); i++)
                    send_elem(rand_elem(mode < 2 ? mode : ($urandom_range(7) < 2 ?
                              $urandom_range(1) : 2)));
                release_elem();
                rounds++;
            end
            // broken round: partial load, then restart by a register write
            set_config(3, 0);
            for (int i = 0; i < 5; i++) send_elem(rand_elem(2));
            release_elem();
        end

        wait_idle();
        if (errors == 0 && expected_prods.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/csmm_pkg.sv
rtl/csmm_if.sv
rtl/csmm_ram.sv
rtl/csmm_cell.sv
rtl/complex_square_matrix_multiply.sv
sim/tb_complex_square_matrix_multiply.sv
